[hdl/floppy_drive_rotation_model_unit_defines.svh]
// assertion macros shared by the block
`ifndef FLOPPY_DRIVE_ROTATION_MODEL_UNIT_DEFINES_SVH
`define FLOPPY_DRIVE_ROTATION_MODEL_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FDRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FDRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/fdrm_pkg.sv]
package fdrm_pkg;

  // drive geometry
  localparam int TRACKS           = 80;
  localparam int TRACK_W          = $clog2(TRACKS);
  localparam int MAX_TRACK_LENGTH = 8191;
  localparam int LEN_W            = 13;
  localparam int LEN_RESET        = 3125;

  // timing
  localparam int TICK_W     = 20;
  localparam int TICK_RESET = 400000;

  // serial arithmetic lane: floor(p * m / d)
  localparam int P_W        = LEN_W + 5;
  localparam int Q_W        = TICK_W;
  localparam int PROD_W     = P_W + Q_W;
  localparam int LANE_STEPS = Q_W;
  localparam int CNT_W      = $clog2(LANE_STEPS);

  // action codes
  localparam logic [1:0] ACT_ROTATE = 2'd0;
  localparam logic [1:0] ACT_SEEK   = 2'd1;
  localparam logic [1:0] ACT_SIDE   = 2'd2;
  localparam logic [1:0] ACT_WRITE  = 2'd3;

  // config register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORTY_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISC       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTECT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS      = 3'd4;

  // lane status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

endpackage

[hdl/fdrm_muldiv.sv]
// bit-serial floor(p * m / d): shift-add multiply, then restoring divide
// caller guarantees p * m < d * 2^Q_W
module fdrm_muldiv (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [fdrm_pkg::P_W-1:0]       p,
  input  logic [fdrm_pkg::Q_W-1:0]       m,
  input  logic [fdrm_pkg::P_W-1:0]       d,
  output fdrm_pkg::lane_stat_t           stat,
  output logic [fdrm_pkg::Q_W-1:0]       q
);

  logic                             run_mul;
  logic                             run_div;
  logic                             done;
  logic [fdrm_pkg::CNT_W-1:0]       cnt;
  logic [fdrm_pkg::PROD_W-1:0]      acc;
  logic [fdrm_pkg::PROD_W-1:0]      acc_next;
  logic [fdrm_pkg::Q_W-1:0]         mreg;
  logic [fdrm_pkg::P_W-1:0]         preg;
  logic [fdrm_pkg::P_W-1:0]         dreg;
  logic [fdrm_pkg::P_W-1:0]         rem;
  logic [fdrm_pkg::P_W:0]           r2;
  logic [fdrm_pkg::P_W:0]           r2_sub;
  logic                             ge;
  logic                             last;

  // one multiplier bit per cycle, msb first
  always_comb begin
    acc_next = {acc[fdrm_pkg::PROD_W-2:0], 1'b0};
    if (mreg[fdrm_pkg::Q_W-1]) begin
      acc_next = acc_next + {{(fdrm_pkg::PROD_W-fdrm_pkg::P_W){1'b0}}, preg};
    end
  end

  // one quotient bit per cycle
  always_comb begin
    r2     = {rem, acc[fdrm_pkg::Q_W-1]};
    r2_sub = r2 - {1'b0, dreg};
    ge     = (r2 >= {1'b0, dreg});
    last   = (cnt == fdrm_pkg::CNT_W'(fdrm_pkg::LANE_STEPS - 1));
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mul <= 1'b0;
      run_div <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run_mul <= 1'b1;
        run_div <= 1'b0;
        cnt     <= '0;
      end else if (run_mul) begin
        if (last) begin
          run_mul <= 1'b0;
          run_div <= 1'b1;
          cnt     <= '0;
        end else begin
          cnt <= cnt + fdrm_pkg::CNT_W'(1);
        end
      end else if (run_div) begin
        if (last) begin
          run_div <= 1'b0;
          done    <= 1'b1;
          cnt     <= '0;
        end else begin
          cnt <= cnt + fdrm_pkg::CNT_W'(1);
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      preg <= p;
      mreg <= m;
      dreg <= d;
      acc  <= '0;
    end else if (run_mul) begin
      acc  <= acc_next;
      mreg <= {mreg[fdrm_pkg::Q_W-2:0], 1'b0};
      if (last) begin
        rem <= acc_next[fdrm_pkg::PROD_W-1:fdrm_pkg::Q_W];
      end
    end else if (run_div) begin
      rem <= ge ? r2_sub[fdrm_pkg::P_W-1:0] : r2[fdrm_pkg::P_W-1:0];
      acc[fdrm_pkg::Q_W-1:0] <= {acc[fdrm_pkg::Q_W-2:0], ge};
    end
  end

  assign stat.busy = run_mul | run_div;
  assign stat.done = done;
  assign q         = acc[fdrm_pkg::Q_W-1:0];

endmodule

[hdl/floppy_drive_rotation_model_unit.sv]
// Floppy drive head over a spinning track.
// Input stream s_*: one action beat (rotate, seek, side select, pulse write);
// the action code rides in s_tuser. Output stream m_*: one result beat per
// action, with the weak-bits flag in m_tuser.
// Config port: cfg_we/cfg_index/cfg_data, to be written by the user only while
// the block is idle; the block itself does not enforce this.
// Rotate, seek and side select run two bit-serial multiply/divide lanes
// (shift-add multiply, then restoring divide); a write skips the lanes.
// One action is in flight at a time: s_tready is high only while idle, so a
// new action is not taken before the last one has reached the output
// register; the serial lanes work one bit per cycle.
// The result sits in an output register; the next action is accepted while
// it waits, and only the following result waits for the receiver.
// Reset (rst, synchronous) returns head, track and side to zero, track length
// to 3125 and the config registers to their defaults; no result is pending.
`include "floppy_drive_rotation_model_unit_defines.svh"
module floppy_drive_rotation_model_unit (
  input  logic                              clk,
  input  logic                              rst,
  // config write port
  input  logic                              cfg_we,
  input  logic [fdrm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fdrm_pkg::TICK_W-1:0]       cfg_data,
  // action input
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // seek_delta, side_choice, disc_word, write_word, track_size, tick_count
  input  logic [119:0]                      s_tdata,
  // action
  input  logic [1:0]                        s_tuser,
  // result output
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // data_word, pulse_count, delay_ticks, head_pos, half_pos, track_now,
  // side_now, index_pulse, flush, write_enable
  output logic [87:0]                       m_tdata,
  // weak_res
  output logic [0:0]                        m_tuser
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  localparam int LEN_W  = fdrm_pkg::LEN_W;
  localparam int TRK_W  = fdrm_pkg::TRACK_W;

  logic [1:0] state;

  // config
  logic                        half_word_mode;
  logic                        forty_track_mode;
  logic                        disc_present;
  logic                        write_protected;
  logic [fdrm_pkg::TICK_W-1:0] ticks_per_rev;

  // drive state
  logic [TRK_W-1:0] track_reg;
  logic             side_reg;
  logic [LEN_W-1:0] head_reg;
  logic             half_reg;
  logic [LEN_W-1:0] length_reg;

  // latched action
  logic [1:0]       act;
  logic [7:0]       delta_in;
  logic             side_in;
  logic [31:0]      disc_in;
  logic [31:0]      wword_in;
  logic [LEN_W-1:0] len_in;
  logic [31:0]      ticks_in;

  // partial result
  logic [31:0]      res_data;
  logic [5:0]       res_count;
  logic             res_weak;
  logic             res_wen;
  logic             sat;

  // output register
  logic [31:0]                 o_data;
  logic [5:0]                  o_count;
  logic                        o_weak;
  logic [fdrm_pkg::TICK_W-1:0] o_delay;
  logic [LEN_W-1:0]            o_head;
  logic                        o_half;
  logic [TRK_W-1:0]            o_track;
  logic                        o_side;
  logic                        o_index;
  logic                        o_flush;
  logic                        o_wen;

  // lanes
  logic                         lane_start;
  logic [fdrm_pkg::P_W-1:0]     pa;
  logic [fdrm_pkg::P_W-1:0]     pb;
  logic [fdrm_pkg::Q_W-1:0]     lane_m;
  logic [fdrm_pkg::P_W-1:0]     lane_d;
  fdrm_pkg::lane_stat_t         stat_a;
  fdrm_pkg::lane_stat_t         stat_b;
  logic [fdrm_pkg::Q_W-1:0]     qa;
  logic [fdrm_pkg::Q_W-1:0]     qb;

  // setup-stage values
  logic [LEN_W-1:0] len_clamp;
  logic [LEN_W-1:0] head0;
  logic             half0;
  logic             cnt16;
  logic [LEN_W-1:0] head1;
  logic             half1;
  logic [31:0]      pulses_raw;
  logic [31:0]      pulses;
  logic [7:0]       weak_byte;
  logic [fdrm_pkg::P_W-1:0] p_cur;
  logic [fdrm_pkg::P_W-1:0] d_old;
  logic [9:0]       delta_ext;
  logic [9:0]       new_trk;
  logic [TRK_W-1:0] trk_clamp;
  logic [31:0]      write_data;

  // finish-stage values
  logic             fin_go;
  logic             wrap;
  logic [LEN_W-1:0] head_fin;
  logic             half_fin;
  logic             flush_fin;
  logic [fdrm_pkg::TICK_W-1:0] delay_fin;
  logic [LEN_W+5:0] head_x50;
  logic             index_fin;

  assign s_tready = (state == S_IDLE);

  // track length of the incoming beat, zero treated as one
  always_comb begin
    len_clamp = s_tdata[85:73];
    if (len_clamp == '0) begin
      len_clamp = LEN_W'(1);
    end else if (len_clamp > LEN_W'(fdrm_pkg::MAX_TRACK_LENGTH)) begin
      len_clamp = LEN_W'(fdrm_pkg::MAX_TRACK_LENGTH);
    end
  end

  // rotate: head restart, half selection, weak bits, next position
  always_comb begin
    if (head_reg >= len_in) begin
      head0 = '0;
      half0 = 1'b0;
    end else begin
      head0 = head_reg;
      half0 = half_reg;
    end
    cnt16      = half0 | half_word_mode;
    pulses_raw = disc_present ? disc_in : 32'd0;
    if (cnt16) begin
      pulses = half0 ? {16'd0, pulses_raw[15:0]} : {16'd0, pulses_raw[31:16]};
    end else begin
      pulses = pulses_raw;
    end
    weak_byte = ticks_in[7:0] ^ ticks_in[15:8] ^ ticks_in[23:16] ^ ticks_in[31:24];
    if (cnt16 && !half0) begin
      head1 = head0;
      half1 = 1'b1;
    end else begin
      head1 = head0 + LEN_W'(1);
      half1 = 1'b0;
    end
    pa    = {head0, half0, 4'd0};
    pb    = {head1, half1, 4'd0};
    p_cur = {head_reg, half_reg, 4'd0};
    d_old = {length_reg, 5'd0};
  end

  // seek: signed delta, doubled in forty-track mode, clamped at the stops
  always_comb begin
    delta_ext = {{2{delta_in[7]}}, delta_in};
    if (forty_track_mode) begin
      delta_ext = {delta_ext[8:0], 1'b0};
    end
    new_trk = {{(10-TRK_W){1'b0}}, track_reg} + delta_ext;
    if (new_trk[9]) begin
      trk_clamp = '0;
    end else if (new_trk > 10'(fdrm_pkg::TRACKS - 1)) begin
      trk_clamp = TRK_W'(fdrm_pkg::TRACKS - 1);
    end else begin
      trk_clamp = new_trk[TRK_W-1:0];
    end
  end

  // write: merge the half under the head in half mode
  always_comb begin
    if (half_word_mode) begin
      if (!half_reg) begin
        write_data = {wword_in[15:0], disc_in[15:0]};
      end else begin
        write_data = {disc_in[31:16], wword_in[15:0]};
      end
    end else begin
      write_data = wword_in;
    end
  end

  // lane operands
  always_comb begin
    lane_start = (state == S_SETUP) && (act != fdrm_pkg::ACT_WRITE);
    if (act == fdrm_pkg::ACT_ROTATE) begin
      lane_m = ticks_per_rev;
      lane_d = {len_in, 5'd0};
    end else begin
      lane_m = {{(fdrm_pkg::Q_W-LEN_W){1'b0}}, len_in};
      lane_d = d_old;
    end
  end

  fdrm_muldiv lane_a (
    .clk   (clk),
    .rst   (rst),
    .start (lane_start),
    .p     ((act == fdrm_pkg::ACT_ROTATE) ? pa : p_cur),
    .m     (lane_m),
    .d     (lane_d),
    .stat  (stat_a),
    .q     (qa)
  );

  fdrm_muldiv lane_b (
    .clk   (clk),
    .rst   (rst),
    .start (lane_start),
    .p     (pb),
    .m     (lane_m),
    .d     (lane_d),
    .stat  (stat_b),
    .q     (qb)
  );

  // final head position, flush, delay and index
  always_comb begin
    fin_go    = (state == S_FIN) && (!m_tvalid || m_tready);
    wrap      = (head_reg >= len_in);
    head_fin  = head_reg;
    half_fin  = half_reg;
    flush_fin = 1'b0;
    delay_fin = '0;
    case (act)
      fdrm_pkg::ACT_ROTATE: begin
        if (wrap) begin
          head_fin  = '0;
          flush_fin = disc_present;
        end
        delay_fin = qb - qa;
      end
      fdrm_pkg::ACT_SEEK, fdrm_pkg::ACT_SIDE: begin
        head_fin  = sat ? (len_in - LEN_W'(1)) : qa[LEN_W-1:0];
        half_fin  = 1'b0;
        flush_fin = disc_present;
      end
      default: begin
        head_fin = head_reg;
      end
    endcase
    head_x50  = {1'b0, head_fin, 5'd0} + {2'd0, head_fin, 4'd0} + {5'd0, head_fin, 1'b0};
    index_fin = !disc_present || (head_x50 < {6'd0, len_in});
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      half_word_mode   <= 1'b0;
      forty_track_mode <= 1'b0;
      disc_present     <= 1'b0;
      write_protected  <= 1'b0;
      ticks_per_rev    <= fdrm_pkg::TICK_W'(fdrm_pkg::TICK_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        fdrm_pkg::CFG_HALF_MODE:  half_word_mode   <= cfg_data[0];
        fdrm_pkg::CFG_FORTY_MODE: forty_track_mode <= cfg_data[0];
        fdrm_pkg::CFG_DISC:       disc_present     <= cfg_data[0];
        fdrm_pkg::CFG_PROTECT:    write_protected  <= cfg_data[0];
        fdrm_pkg::CFG_TICKS:      ticks_per_rev    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and drive state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      track_reg  <= '0;
      side_reg   <= 1'b0;
      head_reg   <= '0;
      half_reg   <= 1'b0;
      length_reg <= LEN_W'(fdrm_pkg::LEN_RESET);
      m_tvalid   <= 1'b0;
    end else begin
      // a new result beat wins over the one just taken
      if (fin_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          length_reg <= len_in;
          case (act)
            fdrm_pkg::ACT_ROTATE: begin
              head_reg <= head1;
              half_reg <= half1;
            end
            fdrm_pkg::ACT_SEEK: track_reg <= trk_clamp;
            fdrm_pkg::ACT_SIDE: side_reg  <= side_in;
            default: ;
          endcase
          state <= (act == fdrm_pkg::ACT_WRITE) ? S_FIN : S_RUN;
        end
        S_RUN: begin
          if (stat_a.done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            head_reg <= head_fin;
            half_reg <= half_fin;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      act      <= s_tuser;
      delta_in <= s_tdata[7:0];
      side_in  <= s_tdata[8];
      disc_in  <= s_tdata[40:9];
      wword_in <= s_tdata[72:41];
      len_in   <= len_clamp;
      ticks_in <= s_tdata[117:86];
    end
  end

  // setup-stage result parts
  always_ff @(posedge clk) begin
    if (state == S_SETUP) begin
      res_data  <= '0;
      res_count <= '0;
      res_weak  <= 1'b0;
      res_wen   <= 1'b0;
      sat       <= (p_cur >= d_old);
      case (act)
        fdrm_pkg::ACT_ROTATE: begin
          res_count <= cnt16 ? 6'd16 : 6'd32;
          if (pulses == '0) begin
            res_data <= {24'd0, weak_byte};
            res_weak <= 1'b1;
          end else begin
            res_data <= pulses;
          end
        end
        fdrm_pkg::ACT_WRITE: begin
          if (disc_present && !write_protected) begin
            res_data <= write_data;
            res_wen  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (fin_go) begin
      o_data  <= res_data;
      o_count <= res_count;
      o_weak  <= res_weak;
      o_delay <= delay_fin;
      o_head  <= head_fin;
      o_half  <= half_fin;
      o_track <= track_reg;
      o_side  <= side_reg;
      o_index <= index_fin;
      o_flush <= flush_fin;
      o_wen   <= res_wen;
    end
  end

  assign m_tdata = {5'd0, o_wen, o_flush, o_index, o_side, o_track, o_half, o_head,
                    o_delay, o_count, o_data};
  assign m_tuser = o_weak;

  // checks
  `FDRM_ASSERT_NOW(a_lanes_in_step, stat_a.done || stat_b.done, stat_a.done && stat_b.done, "lanes out of step")
  `FDRM_ASSERT_NEXT(a_accept_setup, s_tvalid && s_tready, state == S_SETUP && !m_tvalid || state == S_SETUP, "beat accepted without setup")
  `FDRM_ASSERT_NOW(a_track_range, state == S_IDLE, track_reg <= TRK_W'(fdrm_pkg::TRACKS - 1), "track beyond end stop")
  `FDRM_ASSERT_NEXT(a_fin_result, fin_go, m_tvalid && state == S_IDLE, "finished action left no result")

endmodule
